FILE: hdl/white_border_trim_box_core_defines.svh
// Assertion macros used by the trim box RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef WHITE_BORDER_TRIM_BOX_CORE_DEFINES_SVH
`define WHITE_BORDER_TRIM_BOX_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define WBT_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define WBT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define WBT_ASSERT_SAME(name, clk, rst, ante, cons)
`define WBT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/wbt_pkg.sv
// Shared widths, constants, register indexes and types of the trim box.
// No dependencies.
`default_nettype none

package wbt_pkg;

   localparam int MAX_DIM = 4096;
   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = POS_W + 1;
   localparam int END_W   = POS_W + 2;
   localparam int PIX_W   = 8;
   localparam int CSR_W   = DIM_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [PIX_W-1:0] WHITE = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_REGION_COL    = 3'd2,
      CSR_REGION_ROW    = 3'd3,
      CSR_REGION_WIDTH  = 3'd4,
      CSR_REGION_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [POS_W-1:0] region_col;
      logic [POS_W-1:0] region_row;
      logic [DIM_W-1:0] region_width;
      logic [DIM_W-1:0] region_height;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             in_region;
      logic             last;
      logic             end_of_image;
   } stage_type;

endpackage

`default_nettype wire

FILE: hdl/wbt_req_if.sv
// Pixel input channel: valid/ready handshake with one grey value.
// Depends on wbt_pkg.
`default_nettype none

interface wbt_req_if import wbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

FILE: hdl/wbt_rsp_if.sv
// Result channel: valid/ready handshake with the trimmed box.
// Depends on wbt_pkg.
`default_nettype none

interface wbt_rsp_if import wbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] trimmed_col;
   logic [DIM_W-1:0] trimmed_width;
   logic [POS_W-1:0] trimmed_row;
   logic [DIM_W-1:0] trimmed_height;
   logic             all_white;

   modport source (output valid, output trimmed_col, output trimmed_width,
                   output trimmed_row, output trimmed_height, output all_white,
                   input ready);
   modport sink   (input valid, input trimmed_col, input trimmed_width,
                   input trimmed_row, input trimmed_height, input all_white,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/wbt_track.sv
// Raster position tracker and input register: classifies each pixel against
// the rectangle and image bounds. Depends on wbt_pkg and wbt_req_if.
`default_nettype none

module wbt_track import wbt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   wbt_req_if.sink         req_ch,
   input  wire logic       retire,
   output logic            stage_valid,
   output stage_type       stage
);

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic             valid_ff, valid_in;
   stage_type        stage_ff, stage_in;

   logic [DIM_W-1:0] img_w;
   logic [DIM_W-1:0] img_h;
   logic [END_W-1:0] col_end;
   logic [END_W-1:0] row_end;
   logic [END_W-1:0] col_x;
   logic [END_W-1:0] row_x;
   logic             accept;
   logic             wrap_col;
   logic             wrap_row;
   logic             in_region;

   always_comb begin
      if (cfg.image_width == '0) begin
         img_w = DIM_W'(1);
      end else if (cfg.image_width > DIM_W'(MAX_DIM)) begin
         img_w = DIM_W'(MAX_DIM);
      end else begin
         img_w = cfg.image_width;
      end
      if (cfg.image_height == '0) begin
         img_h = DIM_W'(1);
      end else if (cfg.image_height > DIM_W'(MAX_DIM)) begin
         img_h = DIM_W'(MAX_DIM);
      end else begin
         img_h = cfg.image_height;
      end
   end

   assign col_end = END_W'(cfg.region_col) + END_W'(cfg.region_width);
   assign row_end = END_W'(cfg.region_row) + END_W'(cfg.region_height);
   assign col_x   = END_W'(col_ff);
   assign row_x   = END_W'(row_ff);

   assign accept   = req_ch.valid && req_ch.ready;
   assign wrap_col = (DIM_W'(col_ff) + DIM_W'(1)) >= img_w;
   assign wrap_row = (DIM_W'(row_ff) + DIM_W'(1)) >= img_h;

   assign in_region = (cfg.region_width != '0) && (cfg.region_height != '0)
                      && (col_ff >= cfg.region_col) && (col_x < col_end)
                      && (row_ff >= cfg.region_row) && (row_x < row_end);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      valid_in = valid_ff;
      stage_in = stage_ff;
      if (retire) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in              = 1'b1;
         stage_in.pixel        = req_ch.pixel;
         stage_in.col          = col_ff;
         stage_in.row          = row_ff;
         stage_in.in_region    = in_region;
         stage_in.last         = in_region && (col_x == col_end - END_W'(1))
                                 && (row_x == row_end - END_W'(1));
         stage_in.end_of_image = wrap_col && wrap_row;
         if (wrap_col) begin
            col_in = '0;
            row_in = wrap_row ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign req_ch.ready = !valid_ff || retire;
   assign stage_valid  = valid_ff;
   assign stage        = stage_ff;

endmodule

`default_nettype wire

FILE: hdl/wbt_box.sv
// Bounding box accumulator and result register: folds classified pixels
// into the box and forms the trimmed result. Depends on wbt_pkg, wbt_rsp_if.
`default_nettype none
`include "white_border_trim_box_core_defines.svh"

module wbt_box import wbt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       stage_valid,
   input  wire stage_type  stage,
   output logic            retire,
   wbt_rsp_if.source       rsp_ch
);

   logic [POS_W-1:0] min_col_ff, min_col_in;
   logic [POS_W-1:0] max_col_ff, max_col_in;
   logic [POS_W-1:0] min_row_ff, min_row_in;
   logic [POS_W-1:0] max_row_ff, max_row_in;
   logic             ink_ff, ink_in;
   logic             out_valid_ff, out_valid_in;
   logic [DIM_W-1:0] col_out_ff, col_out_in;
   logic [DIM_W-1:0] width_out_ff, width_out_in;
   logic [POS_W-1:0] row_out_ff, row_out_in;
   logic [DIM_W-1:0] height_out_ff, height_out_in;
   logic             white_out_ff, white_out_in;

   logic [DIM_W-1:0] col_end;
   logic             hit;

   assign retire  = stage_valid && (!stage.last || !out_valid_ff || rsp_ch.ready);
   assign hit     = stage.in_region && (stage.pixel != WHITE);
   assign col_end = DIM_W'(cfg.region_col) + cfg.region_width;

   always_comb begin
      min_col_in    = min_col_ff;
      max_col_in    = max_col_ff;
      min_row_in    = min_row_ff;
      max_row_in    = max_row_ff;
      ink_in        = ink_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      col_out_in    = col_out_ff;
      width_out_in  = width_out_ff;
      row_out_in    = row_out_ff;
      height_out_in = height_out_ff;
      white_out_in  = white_out_ff;
      if (retire) begin
         if (hit) begin
            if (!ink_ff) begin
               min_col_in = stage.col;
               max_col_in = stage.col;
               min_row_in = stage.row;
               max_row_in = stage.row;
            end else begin
               if (stage.col < min_col_ff) min_col_in = stage.col;
               if (stage.col > max_col_ff) max_col_in = stage.col;
               if (stage.row < min_row_ff) min_row_in = stage.row;
               if (stage.row > max_row_ff) max_row_in = stage.row;
            end
            ink_in = 1'b1;
         end
         if (stage.last) begin
            out_valid_in = 1'b1;
            if (ink_ff || hit) begin
               col_out_in    = DIM_W'(min_col_in);
               width_out_in  = DIM_W'(max_col_in) - DIM_W'(min_col_in) + DIM_W'(1);
               row_out_in    = min_row_in;
               height_out_in = DIM_W'(max_row_in) - DIM_W'(min_row_in) + DIM_W'(1);
               white_out_in  = 1'b0;
            end else begin
               col_out_in    = col_end;
               width_out_in  = '0;
               row_out_in    = cfg.region_row;
               height_out_in = cfg.region_height;
               white_out_in  = 1'b1;
            end
         end
         if (stage.last || stage.end_of_image) begin
            ink_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ink_ff       <= ink_in;
         out_valid_ff <= out_valid_in;
      end
      min_col_ff    <= min_col_in;
      max_col_ff    <= max_col_in;
      min_row_ff    <= min_row_in;
      max_row_ff    <= max_row_in;
      col_out_ff    <= col_out_in;
      width_out_ff  <= width_out_in;
      row_out_ff    <= row_out_in;
      height_out_ff <= height_out_in;
      white_out_ff  <= white_out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.trimmed_col    = col_out_ff;
   assign rsp_ch.trimmed_width  = width_out_ff;
   assign rsp_ch.trimmed_row    = row_out_ff;
   assign rsp_ch.trimmed_height = height_out_ff;
   assign rsp_ch.all_white      = white_out_ff;

   `WBT_ASSERT_SAME(box_cols_ordered, clock, reset, ink_ff, min_col_ff <= max_col_ff)
   `WBT_ASSERT_SAME(box_rows_ordered, clock, reset, ink_ff, min_row_ff <= max_row_ff)
   `WBT_ASSERT_NEXT(last_gives_result, clock, reset, retire && stage.last, out_valid_ff)
   `WBT_ASSERT_SAME(ink_result_nonzero, clock, reset, out_valid_ff && !white_out_ff,
                    width_out_ff != '0 && height_out_ff != '0)

endmodule

`default_nettype wire

FILE: hdl/white_border_trim_box_core.sv
// Top level of the white border trim box: control registers, raster tracker
// and box accumulator. Depends on wbt_pkg, wbt_req_if, wbt_rsp_if, wbt_track, wbt_box.
//
//   port group   role      transfer condition
//   req_ch       sink      valid && ready, one pixel
//   rsp_ch       source    valid && ready, one trimmed box
//   csr_*        write     csr_wen high, no back-pressure
//
// Throughput is one pixel per cycle but for the stall below; result valid rises
// after the pixel transfer (input register first, then the result register).
// The result register and input register together hold one pending item
// each, so a pixel is still taken while a result waits on rsp_ch.
// Only the rectangle's last pixel stalls behind an untaken result.
// Synchronous active-high reset; no clearing pass after reset.
`default_nettype none

module white_border_trim_box_core import wbt_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   wbt_req_if.sink                   req_ch,
   wbt_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_wen,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   stage_type stage;
   logic      stage_valid;
   logic      retire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata;
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata;
            CSR_REGION_COL:    cfg_in.region_col    = csr_wdata[POS_W-1:0];
            CSR_REGION_ROW:    cfg_in.region_row    = csr_wdata[POS_W-1:0];
            CSR_REGION_WIDTH:  cfg_in.region_width  = csr_wdata;
            CSR_REGION_HEIGHT: cfg_in.region_height = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= DIM_W'(MAX_DIM);
         cfg_ff.image_height  <= DIM_W'(MAX_DIM);
         cfg_ff.region_col    <= '0;
         cfg_ff.region_row    <= '0;
         cfg_ff.region_width  <= DIM_W'(MAX_DIM);
         cfg_ff.region_height <= DIM_W'(MAX_DIM);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wbt_track u_track (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_ch      (req_ch),
      .retire      (retire),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   wbt_box u_box (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .stage_valid (stage_valid),
      .stage       (stage),
      .retire      (retire),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: test/tb_white_border_trim_box_core.sv
`timescale 1ns / 1ps
// Testbench for white_border_trim_box_core: streams raster images, predicts the trimmed
// box of every region and checks each result transfer in order against that prediction.
// Depends on wbt_pkg, wbt_req_if, wbt_rsp_if and the core itself.

module tb_white_border_trim_box_core;
   import wbt_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD    = 250;

   typedef struct packed {
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] width;
      logic [POS_W-1:0] row;
      logic [DIM_W-1:0] height;
      logic             all_white;
   } trim_box_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wen = 1'b0;
   csr_index_type        csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 pix_valid = 1'b0;
   logic [PIX_W-1:0]     pix_data = '0;
   logic                 box_ready = 1'b0;

   wbt_req_if req_ch ();
   wbt_rsp_if rsp_ch ();

   assign req_ch.valid = pix_valid;
   assign req_ch.pixel = pix_data;
   assign rsp_ch.ready = box_ready;

   white_border_trim_box_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [PIX_W-1:0] pending_pixels [$];
   trim_box_type     expected_boxes [$];
   int unsigned      pixels_queued = 0;
   int unsigned      pixels_offered = 0;
   int unsigned      pixels_taken = 0;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   bit               hold_go = 1'b0;

   // shadow copy of the block's registers and raster state
   cfg_type          shadow_cfg;
   int unsigned      col_at, row_at;
   int unsigned      ink_c0, ink_c1, ink_r0, ink_r1;
   bit               ink_seen;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic step_box(input logic [PIX_W-1:0] pix);
      int unsigned iw, ih, col_end, row_end;
      bit in_region, last;
      trim_box_type box;
      iw = clamp_dim(shadow_cfg.image_width);
      ih = clamp_dim(shadow_cfg.image_height);
      col_end = int'(shadow_cfg.region_col) + int'(shadow_cfg.region_width);
      row_end = int'(shadow_cfg.region_row) + int'(shadow_cfg.region_height);
      in_region = shadow_cfg.region_width != '0 && shadow_cfg.region_height != '0 &&
                  col_at >= int'(shadow_cfg.region_col) && col_at < col_end &&
                  row_at >= int'(shadow_cfg.region_row) && row_at < row_end;
      if (in_region && pix != WHITE) begin
         if (!ink_seen) begin
            ink_c0 = col_at;
            ink_c1 = col_at;
            ink_r0 = row_at;
            ink_r1 = row_at;
            ink_seen = 1'b1;
         end else begin
            if (col_at < ink_c0) ink_c0 = col_at;
            if (col_at > ink_c1) ink_c1 = col_at;
            if (row_at < ink_r0) ink_r0 = row_at;
            if (row_at > ink_r1) ink_r1 = row_at;
         end
      end
      last = in_region && col_at == col_end - 1 && row_at == row_end - 1;
      if (last) begin
         if (ink_seen) begin
            box.col       = DIM_W'(ink_c0);
            box.width     = DIM_W'(ink_c1 - ink_c0 + 1);
            box.row       = POS_W'(ink_r0);
            box.height    = DIM_W'(ink_r1 - ink_r0 + 1);
            box.all_white = 1'b0;
         end else begin
            box.col       = DIM_W'(col_end);
            box.width     = '0;
            box.row       = shadow_cfg.region_row;
            box.height    = shadow_cfg.region_height;
            box.all_white = 1'b1;
         end
         expected_boxes.push_back(box);
         ink_seen = 1'b0;
      end
      if (col_at + 1 >= iw) begin
         col_at = 0;
         if (row_at + 1 >= ih) begin
            row_at = 0;
            ink_seen = 1'b0;
         end else begin
            row_at++;
         end
      end else begin
         col_at++;
      end
   endtask

   task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // predict on every pixel transfer, check every result transfer
   always @(posedge clock) begin
      trim_box_type got, want;
      if (reset) begin
         shadow_cfg <= '{image_width: DIM_W'(MAX_DIM), image_height: DIM_W'(MAX_DIM),
                         region_col: '0, region_row: '0,
                         region_width: DIM_W'(MAX_DIM), region_height: DIM_W'(MAX_DIM)};
         col_at   <= 0;
         row_at   <= 0;
         ink_c0   <= 0;
         ink_c1   <= 0;
         ink_r0   <= 0;
         ink_r1   <= 0;
         ink_seen <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   shadow_cfg.image_width   = csr_wdata;
               CSR_IMAGE_HEIGHT:  shadow_cfg.image_height  = csr_wdata;
               CSR_REGION_COL:    shadow_cfg.region_col    = csr_wdata[POS_W-1:0];
               CSR_REGION_ROW:    shadow_cfg.region_row    = csr_wdata[POS_W-1:0];
               CSR_REGION_WIDTH:  shadow_cfg.region_width  = csr_wdata;
               CSR_REGION_HEIGHT: shadow_cfg.region_height = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            pixels_taken++;
            step_box(req_ch.pixel);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.col       = rsp_ch.trimmed_col;
            got.width     = rsp_ch.trimmed_width;
            got.row       = rsp_ch.trimmed_row;
            got.height    = rsp_ch.trimmed_height;
            got.all_white = rsp_ch.all_white;
            if (expected_boxes.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
               error_count++;
            end else begin
               want = expected_boxes.pop_front();
               cmp_field("trimmed_col", want.col, got.col);
               cmp_field("trimmed_width", want.width, got.width);
               cmp_field("trimmed_row", want.row, got.row);
               cmp_field("trimmed_height", want.height, got.height);
               cmp_field("all_white", want.all_white, got.all_white);
            end
         end
      end
   end

   // pixel sender: bursts of random length separated by random gaps
   always @(negedge clock) begin
      int burst_left, gap_left;
      bit busy;
      if (reset) begin
         burst_left = 1;
         gap_left = 0;
         pix_valid <= 1'b0;
      end else begin
         busy = pix_valid && (pixels_offered != pixels_taken);
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
               pix_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               pix_data <= pending_pixels.pop_front();
               pix_valid <= 1'b1;
               pixels_offered++;
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 5) == 0) begin
                     burst_left = $urandom_range(40, 120);
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 16);
                     gap_left = $urandom_range(0, 7);
                  end
               end
            end else begin
               pix_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: stall pattern of its own plus one long hold-off
   always @(negedge clock) begin
      int mode, mode_left, hold_left;
      bit hold_done;
      if (reset) begin
         mode = 0;
         mode_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
         box_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         box_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         box_ready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (mode)
            0:       box_ready <= 1'b1;
            1:       box_ready <= 1'($urandom_range(0, 1));
            default: box_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic wait_idle();
      while (!(pixels_taken == pixels_queued && expected_boxes.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
   endtask

   task automatic set_cfg(input int iw, input int ih, input int rc, input int rr,
                          input int rw, input int rh);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, iw);
      write_csr(CSR_IMAGE_HEIGHT, ih);
      write_csr(CSR_REGION_COL, rc);
      write_csr(CSR_REGION_ROW, rr);
      write_csr(CSR_REGION_WIDTH, rw);
      write_csr(CSR_REGION_HEIGHT, rh);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] p);
      pending_pixels.push_back(p);
      pixels_queued++;
   endtask

   // whole images: white around a random ink box, all white or all noise; noise outside
   task automatic push_images(input int iwe, input int ihe, input int rc, input int rr,
                              input int rw, input int rh, input int nimg);
      int kind, cmax, rmax, bc0, bc1, br0, br1;
      bit in_rect, in_sub;
      logic [PIX_W-1:0] p;
      cmax = rc + ((rw > 0) ? rw - 1 : 0);
      rmax = rr + ((rh > 0) ? rh - 1 : 0);
      for (int n = 0; n < nimg; n++) begin
         kind = $urandom_range(0, 7);
         bc0 = $urandom_range(rc, cmax);
         bc1 = $urandom_range(bc0, cmax);
         br0 = $urandom_range(rr, rmax);
         br1 = $urandom_range(br0, rmax);
         for (int r = 0; r < ihe; r++) begin
            for (int c = 0; c < iwe; c++) begin
               in_rect = c >= rc && c < rc + rw && r >= rr && r < rr + rh;
               in_sub = c >= bc0 && c <= bc1 && r >= br0 && r <= br1;
               if (!in_rect)
                  p = $urandom_range(0, 1) ? WHITE : PIX_W'($urandom_range(0, 255));
               else if (kind == 0)
                  p = WHITE;
               else if (kind == 1)
                  p = PIX_W'($urandom_range(0, 255));
               else if (in_sub && $urandom_range(0, 3) == 0)
                  p = PIX_W'($urandom_range(0, 254));
               else
                  p = WHITE;
               push_pixel(p);
            end
         end
      end
   endtask

   task automatic run_phase(input int iw, input int ih, input int rc, input int rr,
                            input int rw, input int rh, input int nimg,
                            output int items);
      int iwe, ihe;
      iwe = clamp_dim(DIM_W'(iw));
      ihe = clamp_dim(DIM_W'(ih));
      set_cfg(iw, ih, rc, rr, rw, rh);
      push_images(iwe, ihe, rc, rr, rw, rh, nimg);
      items = iwe * ihe * nimg;
   endtask

   initial begin
      logic [PIX_W-1:0] small_img [12] = '{8'd0, 8'd0, 8'd0, 8'd0,
                                           8'd255, 8'd255, 8'd7, 8'd0,
                                           8'd0, 8'd200, 8'd255, 8'd0};
      int iw, ih, rc, rr, rw, rh, items, random_items;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-pixel images: dark, white, near-white, mid grey
      set_cfg(1, 1, 0, 0, 1, 1);
      push_pixel(8'd0);
      push_pixel(WHITE);
      push_pixel(8'd254);
      push_pixel(8'd128);

      // region inside a larger image with mostly dark pixels around it
      set_cfg(4, 3, 1, 1, 2, 2);
      foreach (small_img[i]) push_pixel(small_img[i]);

      // zero-width region never reports
      set_cfg(2, 1, 0, 4095, 0, 8191);
      push_pixel(8'd0);
      push_pixel(8'd1);

      // region running past the image edge: box updates, then clears at image end
      set_cfg(3, 2, 1, 0, 3, 2);
      repeat (6) push_pixel(8'd3);

      // reconfigure part way through an image
      set_cfg(3, 3, 0, 0, 3, 3);
      push_pixel(8'd0);
      repeat (3) push_pixel(WHITE);
      set_cfg(2, 2, 0, 0, 2, 2);
      push_pixel(WHITE);

      // long receiver hold-off while every pixel yields a result
      set_cfg(0, 0, 0, 0, 1, 1);
      hold_go = 1'b1;
      repeat (30) push_pixel(PIX_W'($urandom_range(0, 255)));

      random_items = 0;
      while (random_items < 1090) begin
         iw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
         ih = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 7) == 0) begin
            rc = $urandom_range(0, 4095);
            rr = $urandom_range(0, 4095);
            rw = $urandom_range(0, 8191);
            rh = $urandom_range(0, 8191);
         end else begin
            rc = $urandom_range(0, clamp_dim(DIM_W'(iw)) - 1);
            rr = $urandom_range(0, clamp_dim(DIM_W'(ih)) - 1);
            rw = $urandom_range(1, clamp_dim(DIM_W'(iw)) - rc);
            rh = $urandom_range(1, clamp_dim(DIM_W'(ih)) - rr);
         end
         run_phase(iw, ih, rc, rr, rw, rh, $urandom_range(1, 4), items);
         random_items += items;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/wbt_pkg.sv
hdl/wbt_req_if.sv
hdl/wbt_rsp_if.sv
hdl/wbt_track.sv
hdl/wbt_box.sv
hdl/white_border_trim_box_core.sv
test/tb_white_border_trim_box_core.sv
